FILE: hdl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

    // Counter width default and field widths
    localparam int CountBitsDef = 12;
    localparam int TrigW        = 8;
    localparam int PrescaleW    = 8;
    localparam int TimeoutW     = 12;
    localparam int DistW        = 13;
    localparam int CfgIndexW    = 2;
    localparam int CfgDataW     = 12;
    localparam int InDataW      = 8;
    localparam int OutDataW     = 24;

    // Register reset values
    localparam int TrigTicksRst    = 15;
    localparam int TicksPerUnitRst = 10;
    localparam int TimeoutRst      = 3800;

    // Distance scale: count * 346 / 2 / 100, kept as quotient plus remainder
    localparam int SoundMps     = 346;
    localparam int DistDiv      = 100;
    localparam int DistPerCount = SoundMps / 2;
    localparam int DistWhole    = DistPerCount / DistDiv;
    localparam int DistFrac     = DistPerCount % DistDiv;
    localparam int RemW         = $clog2(DistDiv);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_MEAS = 2'd3
    } t_phase;

    typedef enum logic [CfgIndexW-1:0] {
        REG_TRIGGER_TICKS  = 2'd0,
        REG_TICKS_PER_UNIT = 2'd1,
        REG_TIMEOUT_UNITS  = 2'd2
    } t_reg_index;

    typedef struct packed {
        logic [TrigW-1:0]     trigger_ticks;
        logic [PrescaleW-1:0] ticks_per_unit;
        logic [TimeoutW-1:0]  timeout_units;
    } t_cfg;

    typedef struct packed {
        logic [DistW-1:0] range_mm;
        logic             timed_out;
        logic             done_res;
        logic             busy_res;
        logic             trigger_level;
    } t_result;

endpackage

FILE: hdl/uer_core.sv
// Measurement sequencer: trigger pulse, echo timing and distance scaling.
module uer_core #(
    parameter int COUNT_BITS = uer_pkg::CountBitsDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_start,
    input  logic            i_echo,
    input  uer_pkg::t_cfg   i_cfg,
    output uer_pkg::t_result o_res
);

    localparam int CmpW = (COUNT_BITS > uer_pkg::TimeoutW) ? COUNT_BITS : uer_pkg::TimeoutW;
    localparam int DW   = uer_pkg::DistW;
    localparam int RW   = uer_pkg::RemW;

    uer_pkg::t_phase r_phase, n_phase;
    logic [uer_pkg::PrescaleW-1:0] r_prescale, n_prescale;
    logic [uer_pkg::TrigW-1:0]     r_trig_cnt, n_trig_cnt;
    logic [COUNT_BITS-1:0]         r_echo_cnt, n_echo_cnt;
    logic [DW-1:0]                 r_dist_q, n_dist_q;
    logic [RW-1:0]                 r_dist_r, n_dist_r;
    logic [DW-1:0]                 r_last_dist, n_last_dist;

    logic [uer_pkg::TrigW-1:0]     trig_inc;
    logic [uer_pkg::PrescaleW-1:0] base_ps, ps_inc;
    logic [COUNT_BITS-1:0]         base_ec;
    logic [DW-1:0]                 base_q;
    logic [RW-1:0]                 base_r;
    logic [RW:0]                   rem_sum;
    logic                          rem_carry;
    logic                          unit_done;
    logic                          ec_step;
    logic                          trig, done, tmo;

    assign trig_inc = r_trig_cnt + uer_pkg::TrigW'(1);

    // On the rising edge the unit counters restart from zero
    assign base_ps = (r_phase == uer_pkg::PH_WAIT) ? '0 : r_prescale;
    assign base_ec = (r_phase == uer_pkg::PH_WAIT) ? '0 : r_echo_cnt;
    assign base_q  = (r_phase == uer_pkg::PH_WAIT) ? '0 : r_dist_q;
    assign base_r  = (r_phase == uer_pkg::PH_WAIT) ? '0 : r_dist_r;

    assign ps_inc    = base_ps + uer_pkg::PrescaleW'(1);
    assign unit_done = (ps_inc >= i_cfg.ticks_per_unit);
    assign ec_step   = unit_done && (base_ec != {COUNT_BITS{1'b1}});

    // Running distance: each count adds 1.73 mm as whole part and hundredths
    assign rem_sum   = {1'b0, base_r} + (RW+1)'(uer_pkg::DistFrac);
    assign rem_carry = (rem_sum >= (RW+1)'(uer_pkg::DistDiv));

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            uer_pkg::PH_IDLE: begin
                if (i_start) begin
                    n_phase = (8'd1 >= i_cfg.trigger_ticks) ? uer_pkg::PH_WAIT
                                                            : uer_pkg::PH_TRIG;
                end
            end
            uer_pkg::PH_TRIG: begin
                if (trig_inc >= i_cfg.trigger_ticks) n_phase = uer_pkg::PH_WAIT;
            end
            uer_pkg::PH_WAIT: begin
                if (i_echo) n_phase = uer_pkg::PH_MEAS;
            end
            uer_pkg::PH_MEAS: begin
                if (!i_echo) n_phase = uer_pkg::PH_IDLE;
            end
        endcase
    end

    // Counters and result flags
    always_comb begin
        n_prescale  = r_prescale;
        n_trig_cnt  = r_trig_cnt;
        n_echo_cnt  = r_echo_cnt;
        n_dist_q    = r_dist_q;
        n_dist_r    = r_dist_r;
        n_last_dist = r_last_dist;
        trig        = 1'b0;
        done        = 1'b0;
        tmo         = 1'b0;
        unique case (r_phase)
            uer_pkg::PH_IDLE: begin
                if (i_start) begin
                    trig       = 1'b1;
                    n_trig_cnt = 8'd1;
                end
            end
            uer_pkg::PH_TRIG: begin
                trig       = 1'b1;
                n_trig_cnt = trig_inc;
            end
            uer_pkg::PH_WAIT, uer_pkg::PH_MEAS: begin
                if (i_echo) begin
                    n_prescale = unit_done ? '0 : ps_inc;
                    n_echo_cnt = ec_step ? base_ec + COUNT_BITS'(1) : base_ec;
                    if (ec_step) begin
                        n_dist_q = base_q + DW'(uer_pkg::DistWhole) + DW'(rem_carry);
                        n_dist_r = rem_carry ? RW'(rem_sum - (RW+1)'(uer_pkg::DistDiv))
                                             : rem_sum[RW-1:0];
                    end else begin
                        n_dist_q = base_q;
                        n_dist_r = base_r;
                    end
                end else if (r_phase == uer_pkg::PH_MEAS) begin
                    done = 1'b1;
                    if (CmpW'(r_echo_cnt) >= CmpW'(i_cfg.timeout_units)) begin
                        tmo         = 1'b1;
                        n_last_dist = '0;
                    end else begin
                        n_last_dist = r_dist_q;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= uer_pkg::PH_IDLE;
            r_prescale  <= '0;
            r_trig_cnt  <= '0;
            r_echo_cnt  <= '0;
            r_dist_q    <= '0;
            r_dist_r    <= '0;
            r_last_dist <= '0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_prescale  <= n_prescale;
            r_trig_cnt  <= n_trig_cnt;
            r_echo_cnt  <= n_echo_cnt;
            r_dist_q    <= n_dist_q;
            r_dist_r    <= n_dist_r;
            r_last_dist <= n_last_dist;
        end
    end

    assign o_res.trigger_level = trig;
    assign o_res.busy_res      = (n_phase != uer_pkg::PH_IDLE);
    assign o_res.done_res      = done;
    assign o_res.timed_out     = tmo;
    assign o_res.range_mm      = n_last_dist;

endmodule

FILE: hdl/ultrasonic_echo_ranger_top.sv
// Top level of the ultrasonic echo ranger: stream ports, registers, output skid.
//
// Usage notes
// - Each input request is one microsecond tick: tdata[0] start_req,
//   tdata[1] echo_level. Every request yields exactly one result request.
// - Result tdata carries, lowest bit up: trigger_level, busy_res, done_res,
//   timed_out, range_mm[12:0], zero padding to 24 bits.
// - The result of an accepted request is registered in the output skid and
//   shown from there on o_m_tvalid/o_m_tdata.
// - One request per cycle while o_s_tready is high; the state update is one
//   pass of logic between the sequencer registers and the result register.
// - The output side is a two-entry skid (main register plus spare), so a
//   request is still taken while one result waits; o_s_tready drops only
//   when both entries are full, i.e. after the receiver stalls while a
//   result waits and a new request arrives.
// - Configuration writes (index 0 trigger_ticks, 1 ticks_per_unit,
//   2 timeout_units) are always accepted; index 3 is ignored.
// - Synchronous active-low reset returns the sequencer to idle, clears the
//   counters and held distance, empties the output and restores register
//   defaults (15, 10, 3800).
module ultrasonic_echo_ranger_top #(
    parameter int COUNT_BITS = uer_pkg::CountBitsDef
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [uer_pkg::InDataW-1:0]     i_s_tdata,   // start_req, echo_level
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [uer_pkg::OutDataW-1:0]    o_m_tdata,   // trigger, busy, done, tmo, dist
    // register writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [uer_pkg::CfgIndexW-1:0]   i_cfg_index,
    input  logic [uer_pkg::CfgDataW-1:0]    i_cfg_data
);

    localparam int ResW = $bits(uer_pkg::t_result);

    uer_pkg::t_cfg    r_cfg;
    uer_pkg::t_result res;
    uer_pkg::t_result r_out, r_skid;
    logic             r_out_valid, r_skid_valid;
    logic             push, pop;

    assign o_cfg_ready = 1'b1;

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks  <= uer_pkg::TrigW'(uer_pkg::TrigTicksRst);
            r_cfg.ticks_per_unit <= uer_pkg::PrescaleW'(uer_pkg::TicksPerUnitRst);
            r_cfg.timeout_units  <= uer_pkg::TimeoutW'(uer_pkg::TimeoutRst);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                uer_pkg::REG_TRIGGER_TICKS:
                    r_cfg.trigger_ticks <= i_cfg_data[uer_pkg::TrigW-1:0];
                uer_pkg::REG_TICKS_PER_UNIT:
                    r_cfg.ticks_per_unit <= i_cfg_data[uer_pkg::PrescaleW-1:0];
                uer_pkg::REG_TIMEOUT_UNITS:
                    r_cfg.timeout_units <= i_cfg_data[uer_pkg::TimeoutW-1:0];
                default: ;
            endcase
        end
    end

    // Request taken whenever the spare entry is free
    assign o_s_tready = !r_skid_valid;
    assign push       = i_s_tvalid && o_s_tready;
    assign pop        = r_out_valid && i_m_tready;

    uer_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (push),
        .i_start (i_s_tdata[0]),
        .i_echo  (i_s_tdata[1]),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // Output skid: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            if (r_out_valid) r_skid_valid <= 1'b1;
            else             r_out_valid  <= 1'b1;
        end
    end

    // Output skid: payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) r_out <= r_skid;
            else if (push)    r_out <= res;
        end else if (push) begin
            if (r_out_valid) r_skid <= res;
            else             r_out  <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(uer_pkg::OutDataW - ResW){1'b0}}, r_out};

endmodule

FILE: hdl/uer_checker.sv
// Port-level checks for the ultrasonic echo ranger, bound to the top level.
module uer_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_m_tvalid,
    input logic                         i_m_tready,
    input logic [uer_pkg::OutDataW-1:0] o_m_tdata
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // A finished measurement leaves the sequencer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2] |-> !o_m_tdata[1] && !o_m_tdata[0])
        else $error("done while still busy");

    // Timeout only with done, and it clears the distance
    a_tmo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[3] |-> o_m_tdata[2] && (o_m_tdata[16:4] == 13'd0))
        else $error("timeout without done or with distance");

    // Trigger is driven only within a measurement
    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |-> o_m_tdata[1])
        else $error("trigger while idle");

    // Reset empties the output
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_uer_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: tb/ultrasonic_echo_ranger_checker.sv
// Checker for the ultrasonic echo ranger: predicts every result request and compares it.
module ultrasonic_echo_ranger_checker
    import uer_pkg::*;
#(
    parameter int COUNT_BITS = CountBitsDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [InDataW-1:0]   i_s_tdata,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [OutDataW-1:0]  i_m_tdata,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [CfgDataW-1:0]  i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_ranges,
    output int                   o_timeouts,
    output int                   o_results
);

    localparam int unsigned UnitTop = (1 << COUNT_BITS) - 1;
    localparam int          ResultW = $bits(t_result);

    // predictor state
    t_cfg                 regs_q;
    t_phase               seq_phase;
    logic [PrescaleW-1:0] prescale_cnt;
    logic [TrigW-1:0]     pulse_cnt;
    int unsigned          unit_cnt;
    logic [DistW-1:0]     held_dist;

    t_result expected_q[$];
    int      fails    = 0;
    int      pending  = 0;
    int      ranges   = 0;
    int      timeouts = 0;
    int      results  = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;
    assign o_ranges     = ranges;
    assign o_timeouts   = timeouts;
    assign o_results    = results;

    // one echo-high tick: prescaler, then a saturating unit count
    function automatic void count_unit_tick();
        prescale_cnt = prescale_cnt + PrescaleW'(1);
        if (prescale_cnt >= regs_q.ticks_per_unit) begin
            prescale_cnt = '0;
            if (unit_cnt < UnitTop) unit_cnt++;
        end
    endfunction

    function automatic t_result ranger_tick(input logic start, input logic echo);
        t_result     r;
        int unsigned mm;
        r = '0;
        case (seq_phase)
            PH_IDLE: begin
                if (start) begin
                    r.trigger_level = 1'b1;
                    pulse_cnt       = 8'd1;
                    if (pulse_cnt >= regs_q.trigger_ticks) seq_phase = PH_WAIT;
                    else seq_phase = PH_TRIG;
                end
            end
            PH_TRIG: begin
                r.trigger_level = 1'b1;
                pulse_cnt       = pulse_cnt + TrigW'(1);
                if (pulse_cnt >= regs_q.trigger_ticks) seq_phase = PH_WAIT;
            end
            PH_WAIT: begin
                if (echo) begin
                    prescale_cnt = '0;
                    unit_cnt     = 0;
                    seq_phase    = PH_MEAS;
                    count_unit_tick();
                end
            end
            default: begin
                if (echo) begin
                    count_unit_tick();
                end else begin
                    r.done_res = 1'b1;
                    if (unit_cnt >= regs_q.timeout_units) begin
                        r.timed_out = 1'b1;
                        held_dist   = '0;
                    end else begin
                        mm        = unit_cnt * SoundMps / 2 / DistDiv;
                        held_dist = mm[DistW-1:0];
                    end
                    seq_phase = PH_IDLE;
                end
            end
        endcase
        r.busy_res = (seq_phase != PH_IDLE);
        r.range_mm = held_dist;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            regs_q.trigger_ticks  = TrigW'(TrigTicksRst);
            regs_q.ticks_per_unit = PrescaleW'(TicksPerUnitRst);
            regs_q.timeout_units  = TimeoutW'(TimeoutRst);
            seq_phase    = PH_IDLE;
            prescale_cnt = '0;
            pulse_cnt    = '0;
            unit_cnt     = 0;
            held_dist    = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_index'(i_cfg_index))
                    REG_TRIGGER_TICKS:  regs_q.trigger_ticks  = i_cfg_data[TrigW-1:0];
                    REG_TICKS_PER_UNIT: regs_q.ticks_per_unit = i_cfg_data[PrescaleW-1:0];
                    REG_TIMEOUT_UNITS:  regs_q.timeout_units  = i_cfg_data[TimeoutW-1:0];
                    default: ;
                endcase
            end
            // result side first: a result never belongs to this edge's request
            if (i_m_tvalid && i_m_tready) begin
                results++;
                got = t_result'(i_m_tdata[ResultW-1:0]);
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got %h", $time, i_m_tdata);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("trigger_level", want.trigger_level, got.trigger_level);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("timed_out", want.timed_out, got.timed_out);
                    check_field("range_mm", want.range_mm, got.range_mm);
                    check_field("padding", 0, i_m_tdata[OutDataW-1:ResultW]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                want = ranger_tick(i_s_tdata[0], i_s_tdata[1]);
                if (want.done_res) ranges++;
                if (want.timed_out) timeouts++;
                expected_q.push_back(want);
            end
        end
        pending = expected_q.size();
    end

endmodule

FILE: tb/ultrasonic_echo_ranger_top_test.sv
// Test bench top for the ultrasonic echo ranger: stimulus, stall patterns and verdict.
module ultrasonic_echo_ranger_top_test;
    import uer_pkg::*;

    localparam int RunLimit      = 400000;  // cycles, well past the slowest legal run
    localparam int RandomTicks   = 1530;
    localparam int PhaseTicks    = 150;
    localparam int HoldCycles    = 80;      // receiver hold-off, fills the output skid
    localparam logic [CfgIndexW-1:0] RegUnused = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [InDataW-1:0]   i_s_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [OutDataW-1:0]  o_m_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CfgIndexW-1:0] i_cfg_index;
    logic [CfgDataW-1:0]  i_cfg_data;

    int fails, pending, ranges, timeouts, results;

    // stimulus bookkeeping
    int          ticks_sent = 0;
    int          reg_writes = 0;
    int          holds      = 0;
    int          hold_left  = 0;
    int          cycles     = 0;
    int unsigned pulse_len  = TrigTicksRst;  // trigger length the block will use
    bit          tx_calm    = 1'b0;          // sender never idles
    bit          rx_calm    = 1'b0;          // receiver never stalls
    bit          hold_req   = 1'b0;          // ask the receiver for one long hold-off

    ultrasonic_echo_ranger_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    ultrasonic_echo_ranger_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fails),
        .o_pending    (pending),
        .o_ranges     (ranges),
        .o_timeouts   (timeouts),
        .o_results    (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin
        while (cycles < RunLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Cycle limit reached with %0d results outstanding", pending);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: random stalls, calm stretches, and one long hold-off on request.
    // The hold-off is counted here so the sender keeps offering requests meanwhile.
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HoldCycles - 1;
                holds++;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= rx_calm || ($urandom_range(99) >= 31);
            end
        end
    end

    // One microsecond tick on the input stream, with random gaps before it.
    task automatic send_tick(input logic start, input logic echo);
        while (!tx_calm && $urandom_range(99) < 31) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(InDataW-2){1'b0}}, echo, start};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
        ticks_sent++;
    endtask

    // Register write, only once every expected result has come back.
    // Every tick yields a result, so an empty queue means the pipe is empty.
    task automatic write_reg(input logic [CfgIndexW-1:0] index, input logic [CfgDataW-1:0] data);
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        reg_writes++;
        @(negedge i_clk);
    endtask

    // All three registers; the unused upper data bits of the 8-bit ones are random.
    task automatic set_config(input logic [7:0] trig, input logic [7:0] unit,
                              input logic [TimeoutW-1:0] tmo);
        write_reg(REG_TRIGGER_TICKS, {4'($urandom_range(15)), trig});
        write_reg(REG_TICKS_PER_UNIT, {4'($urandom_range(15)), unit});
        write_reg(REG_TIMEOUT_UNITS, tmo);
        pulse_len = (trig == 8'd0) ? 1 : trig;
    endtask

    // A well-formed ranging cycle with random content. It opens with an echo
    // blip so that a block left waiting by an earlier sequence finishes first.
    // Stray starts while busy and echo during the trigger pulse are sprinkled in.
    task automatic measure(input int gap, input int high_len, input bit never_rise);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'($urandom_range(1)));
        repeat (pulse_len - 1) send_tick($urandom_range(7) == 0, 1'($urandom_range(1)));
        repeat (gap) send_tick($urandom_range(7) == 0, 1'b0);
        if (!never_rise) begin
            repeat (high_len) send_tick($urandom_range(7) == 0, 1'b1);
            send_tick(1'($urandom_range(1)), 1'b0);
        end
    endtask

    initial begin
        int          ph;
        int          choice;
        int          gap;
        int          high_len;
        int          phase_end;
        int          pick;
        logic [7:0]  trig;
        logic [7:0]  unit;
        logic [11:0] tmo;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_TRIGGER_TICKS;
        i_cfg_data  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed part ---
        // idle: echo alone does nothing
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        // write to the unused index must change nothing
        write_reg(RegUnused, 12'hFFF);
        // zero trigger length and zero prescale both act as one
        set_config(8'd0, 8'd0, 12'd4095);
        send_tick(1'b1, 1'b1);   // start; echo on the trigger tick is ignored
        send_tick(1'b1, 1'b1);   // echo already high: rising edge at once, start ignored
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);   // echo falls, start on the done tick ignored
        send_tick(1'b1, 1'b0);   // fresh start
        send_tick(1'b0, 1'b0);   // echo slow to rise, block keeps waiting
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        // zero timeout: every finished measurement is a timeout
        set_config(8'd2, 8'd255, 12'd0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);

        // --- random phases, a fresh register setting for each ---
        ph = 0;
        phase_end = ticks_sent + RandomTicks;
        while (ticks_sent < phase_end) begin
            if (ph == 1) begin
                // slowest setting: longest pulse, coarsest prescale, tiny timeout
                trig = 8'd255;
                unit = 8'd255;
                tmo  = 12'd1;
            end else begin
                pick = $urandom_range(9);
                trig = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : (pick == 2) ? 8'd1 :
                       8'($urandom_range(1, 12));
                pick = $urandom_range(7);
                unit = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : (pick == 2) ? 8'd1 :
                       8'($urandom_range(1, 8));
                pick = $urandom_range(7);
                tmo  = (pick < 4) ? 12'($urandom_range(1, 40)) :
                       (pick == 4) ? 12'($urandom) : (pick == 5) ? 12'd4095 :
                       (pick == 6) ? 12'd0 : 12'd1;
            end
            set_config(trig, unit, tmo);
            // first phase runs flat out on both sides
            tx_calm = (ph == 0);
            rx_calm = (ph == 0);
            if (ph == 2) hold_req = 1'b1;

            choice = ticks_sent + PhaseTicks;
            while (ticks_sent < choice) begin
                pick = $urandom_range(9);
                gap  = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                high_len = ($urandom_range(5) == 0) ? $urandom_range(41, 200) :
                           $urandom_range(1, 40);
                if (pick < 7) begin
                    measure(gap, high_len, 1'b0);
                end else if (pick == 7) begin
                    // echo never comes back within the sequence
                    measure($urandom_range(10, 40), 0, 1'b1);
                end else begin
                    repeat ($urandom_range(1, 8))
                        send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            end
            ph++;
        end

        // --- drain and verdict ---
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("Covered %0d ticks over %0d register writes in %0d random phases.",
                 ticks_sent, reg_writes, ph);
        $display("Saw %0d ranging results (%0d timed out), %0d long hold-offs, %0d checked.",
                 ranges, timeouts, holds, results);
        if (fails == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/uer_pkg.sv
hdl/uer_core.sv
hdl/ultrasonic_echo_ranger_top.sv
hdl/uer_checker.sv
tb/ultrasonic_echo_ranger_checker.sv
tb/ultrasonic_echo_ranger_top_test.sv
